>>> rtl/multichannel_iir_filter_core_macros.svh
// ----------------------------------------------------------------------------
// multichannel iir filter core assertion macros
// shared concurrent assertion helpers for the filter rtl
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_IIR_FILTER_CORE_MACROS_SVH
`define MULTICHANNEL_IIR_FILTER_CORE_MACROS_SVH

// property must hold on every clock edge outside reset
`define MIF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen outside reset
`define MIF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> rtl/mif_pkg.sv
// ----------------------------------------------------------------------------
// mif_pkg
// shared types and constants of the multichannel iir filter core
// ----------------------------------------------------------------------------
`default_nettype none

package mif_pkg;

  localparam int CHAN_BITS     = 3;
  localparam int COEF_BITS     = 18;
  localparam int FRAC_BITS     = 16;
  localparam int COEF_TAPS     = 4;
  localparam int TAP_IDX_BITS  = 2;
  localparam int ORDER_BITS    = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 18;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORDER = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FF0   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FF3   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_FB1   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_FB3   = 3'd7;

  localparam logic [ORDER_BITS-1:0]          ORDER_RESET = 3'd2;
  localparam logic signed [COEF_BITS-1:0]    FF0_RESET   = 18'sd65536;

  typedef struct packed {
    logic clear;
    logic valid;
    logic sub;
  } mac_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/mif_ram.sv
// ----------------------------------------------------------------------------
// mif_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mif_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/mif_mac.sv
// ----------------------------------------------------------------------------
// mif_mac
// registered multiply accumulate with rounding and saturation of the sum
// ----------------------------------------------------------------------------
`default_nettype none

module mif_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  mif_pkg::mac_ctrl_t                      ctrl_i,
  input  logic signed [mif_pkg::COEF_BITS-1:0]    coef_i,
  input  logic signed [SAMPLE_BITS-1:0]           operand_i,
  output logic signed [SAMPLE_BITS-1:0]           y_o
);

  import mif_pkg::*;

  localparam int PW    = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W = PW + 3;
  localparam int QW    = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [QW-1:0] SAT_HI =
    {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_LO =
    {{(QW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PW-1:0]    prod_q;
  logic                    prod_vld_q;
  logic                    sub_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] rsum;
  logic signed [QW-1:0]    quot;

  assign prod_ext = {{(ACC_W-PW){prod_q[PW-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      sub_q      <= 1'b0;
      acc_q      <= '0;
    end else if (ctrl_i.clear) begin
      prod_vld_q <= 1'b0;
      sub_q      <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.valid;
      sub_q      <= ctrl_i.sub;
      if (prod_vld_q) begin
        acc_q <= sub_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= coef_i * operand_i;
    end
  end

  // round half up, floor shift, clamp to sample range
  assign rsum = acc_q + ROUND_C;
  assign quot = QW'(rsum >>> FRAC_BITS);

  always_comb begin
    if (quot > SAT_HI) begin
      y_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (quot < SAT_LO) begin
      y_o = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_o = quot[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/multichannel_iir_filter_core.sv
// ----------------------------------------------------------------------------
// multichannel_iir_filter_core
// direct form i iir filter shared by several channels, histories in ram
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid_i / in_stall_o with channel_i and sample_i. one
//   transaction per sample; the core works on one sample at a time.
//   output channel: out_valid_o / out_stall_i with channel_out_o and
//   filtered_o, one transaction per input sample, in input order.
//   config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i,
//   always ready; write only while no sample is in flight.
//   sequence: with t active taps (order, at least 1, at most 4), a sample
//   passes load, 2*t-1 multiply steps, drain, finish and idle from acceptance
//   to the next acceptance; the result is valid the cycle after finish. the
//   steps come from the single shared multiplier doing one tap per cycle and
//   from the registered history ram read.
//   the finished result sits in an output register; when the receiver
//   stalls, the next sample is still accepted and computed, and it waits in
//   the finish step until the output register is free.
//   reset: clears the started flags and restores register defaults; the
//   history rams need no clearing, since the first sample of a channel
//   overwrites its rows.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_iir_filter_core_macros.svh"

module multichannel_iir_filter_core #(
  parameter int NUM_CHANNELS = 8,
  parameter int MAX_ORDER    = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [mif_pkg::CHAN_BITS-1:0]         channel_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [mif_pkg::CHAN_BITS-1:0]         channel_out_o,
  output logic signed [SAMPLE_BITS-1:0]         filtered_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mif_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [mif_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  import mif_pkg::*;

  localparam int CH_AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ROW_W   = MAX_ORDER * SAMPLE_BITS;
  localparam int TAP_LIM = (MAX_ORDER < COEF_TAPS) ? MAX_ORDER : COEF_TAPS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } state_e;

  typedef logic [MAX_ORDER-1:0][SAMPLE_BITS-1:0] row_t;

  function automatic logic [CH_AW-1:0] chan_map(input logic [CHAN_BITS-1:0] c);
    logic [CHAN_BITS:0] v;
    v = {1'b0, c};
    for (int i = 0; i < (1 << CHAN_BITS); i++) begin
      if (int'(v) >= NUM_CHANNELS) begin
        v = v - (CHAN_BITS+1)'(NUM_CHANNELS);
      end
    end
    return CH_AW'(v);
  endfunction

  // configuration registers
  logic [ORDER_BITS-1:0]       order_q;
  logic signed [COEF_BITS-1:0] ff_q [COEF_TAPS];
  logic signed [COEF_BITS-1:0] fb_q [COEF_TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
      for (int k = 0; k < COEF_TAPS; k++) begin
        ff_q[k] <= '0;
        fb_q[k] <= '0;
      end
      ff_q[0] <= FF0_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        REG_ORDER: begin
          order_q <= cfg_data_i[ORDER_BITS-1:0];
        end
        [REG_FF0:REG_FF3]: begin
          ff_q[TAP_IDX_BITS'(cfg_index_i - REG_FF0)] <= cfg_data_i;
        end
        [REG_FB1:REG_FB3]: begin
          fb_q[TAP_IDX_BITS'(cfg_index_i - REG_FB1 + 3'd1)] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // active taps and last multiply step
  logic [ORDER_BITS-1:0] taps;
  logic [2:0]            last_step;

  always_comb begin
    if (order_q == '0) begin
      taps = ORDER_BITS'(1);
    end else if ({1'b0, order_q} > (ORDER_BITS+1)'(TAP_LIM)) begin
      taps = ORDER_BITS'(TAP_LIM);
    end else begin
      taps = order_q;
    end
  end

  assign last_step = 3'({taps, 1'b0} - 4'd2);

  // sequencer
  state_e                       state_q;
  logic [2:0]                   step_q;
  logic [CHAN_BITS-1:0]         chan_q;
  logic [CH_AW-1:0]             ch_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  row_t                         xrow_q;
  row_t                         yrow_q;
  row_t                         xrow_d;
  row_t                         yrow_d;
  row_t                         yrow_wr;
  logic [NUM_CHANNELS-1:0]      started_q;
  logic                         out_valid_q;
  logic [CHAN_BITS-1:0]         channel_out_q;
  logic signed [SAMPLE_BITS-1:0] filtered_q;

  logic                         in_accept;
  logic                         fin_go;
  logic [ROW_W-1:0]             xram_rdata;
  logic [ROW_W-1:0]             yram_rdata;
  row_t                         xold;
  row_t                         yold;
  logic                         ch_started;
  logic signed [SAMPLE_BITS-1:0] mac_y;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign fin_go     = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  assign xold       = xram_rdata;
  assign yold       = yram_rdata;
  assign ch_started = started_q[ch_q];

  // warm start and input shift
  always_comb begin
    xrow_d[0] = x_q;
    for (int k = 1; k < MAX_ORDER; k++) begin
      xrow_d[k] = ch_started ? xold[k-1] : x_q;
    end
    for (int k = 0; k < MAX_ORDER; k++) begin
      yrow_d[k] = ch_started ? yold[k] : x_q;
    end
  end

  always_comb begin
    yrow_wr[0] = mac_y;
    for (int k = 1; k < MAX_ORDER; k++) begin
      yrow_wr[k] = yrow_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      started_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            chan_q  <= channel_i;
            ch_q    <= chan_map(channel_i);
            x_q     <= sample_i;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          xrow_q  <= xrow_d;
          yrow_q  <= yrow_d;
          step_q  <= '0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          if (step_q == last_step) begin
            state_q <= ST_DRAIN;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            channel_out_q   <= chan_q;
            filtered_q      <= mac_y;
            started_q[ch_q] <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = channel_out_q;
  assign filtered_o    = filtered_q;

  // tap operands
  logic signed [SAMPLE_BITS-1:0] xtap [COEF_TAPS];
  logic signed [SAMPLE_BITS-1:0] ytap [COEF_TAPS];

  for (genvar k = 0; k < COEF_TAPS; k++) begin : g_tap
    if (k < MAX_ORDER) begin : g_used
      assign xtap[k] = xrow_q[k];
      assign ytap[k] = yrow_q[k];
    end else begin : g_zero
      assign xtap[k] = '0;
      assign ytap[k] = '0;
    end
  end

  logic                          fb_phase;
  logic [2:0]                    fb_step;
  mac_ctrl_t                     mac_ctrl;
  logic signed [COEF_BITS-1:0]   mac_coef;
  logic signed [SAMPLE_BITS-1:0] mac_operand;

  assign fb_phase = (step_q >= taps);
  assign fb_step  = step_q - taps;

  always_comb begin
    mac_ctrl.clear = (state_q == ST_LOAD);
    mac_ctrl.valid = (state_q == ST_MAC);
    mac_ctrl.sub   = fb_phase;
    if (fb_phase) begin
      mac_coef    = fb_q[TAP_IDX_BITS'(fb_step + 3'd1)];
      mac_operand = ytap[fb_step[TAP_IDX_BITS-1:0]];
    end else begin
      mac_coef    = ff_q[step_q[TAP_IDX_BITS-1:0]];
      mac_operand = xtap[step_q[TAP_IDX_BITS-1:0]];
    end
  end

  mif_mac #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .coef_i    (mac_coef),
    .operand_i (mac_operand),
    .y_o       (mac_y)
  );

  mif_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_CHANNELS)
  ) u_xram (
    .clk_i   (clk_i),
    .we_i    (fin_go),
    .waddr_i (ch_q),
    .wdata_i (xrow_q),
    .re_i    (in_accept),
    .raddr_i (chan_map(channel_i)),
    .rdata_o (xram_rdata)
  );

  mif_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_CHANNELS)
  ) u_yram (
    .clk_i   (clk_i),
    .we_i    (fin_go),
    .waddr_i (ch_q),
    .wdata_i (yrow_wr),
    .re_i    (in_accept),
    .raddr_i (chan_map(channel_i)),
    .rdata_o (yram_rdata)
  );

  // assertions
  `MIF_ASSERT(a_accept_loads, clk_i, rst_ni,
    in_accept |=> (state_q == ST_LOAD), "accepted sample did not start a ram load")
  `MIF_ASSERT_NEVER(a_step_range, clk_i, rst_ni,
    (state_q == ST_MAC) && (step_q > last_step), "multiply step beyond last tap")
  `MIF_ASSERT(a_started_set, clk_i, rst_ni,
    fin_go |=> started_q[$past(ch_q)], "channel not marked started after result")

endmodule

`default_nettype wire

>>> tb/multichannel_iir_filter_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel iir filter core checker
// watches the sample, result and config channels, keeps its own copy of the
// per-channel histories and registers, and compares every result transaction
// field by field with the oldest predicted result
// ----------------------------------------------------------------------------

module multichannel_iir_filter_core_checker #(
  parameter int NUM_CHANNELS = 8,
  parameter int MAX_ORDER    = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [mif_pkg::CHAN_BITS-1:0]       channel_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [mif_pkg::CHAN_BITS-1:0]       channel_out_i,
  input  logic signed [SAMPLE_BITS-1:0]       filtered_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [mif_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [mif_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output int                                  mismatches_o,
  output int                                  pending_o
);

  import mif_pkg::*;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          chan;
    logic signed [SAMPLE_BITS-1:0] value;
  } filter_out_t;

  logic signed [SAMPLE_BITS-1:0] x_hist [NUM_CHANNELS][MAX_ORDER];
  logic signed [SAMPLE_BITS-1:0] y_hist [NUM_CHANNELS][MAX_ORDER];
  logic                          started [NUM_CHANNELS];
  logic [ORDER_BITS-1:0]         order_q;
  logic signed [COEF_BITS-1:0]   ff_q [COEF_TAPS];
  logic signed [COEF_BITS-1:0]   fb_q [COEF_TAPS];

  filter_out_t filtered_q[$];
  filter_out_t fresh;
  filter_out_t oldest;
  int          mismatch_cnt;
  int          pending_cnt;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
    input int ch, input logic signed [SAMPLE_BITS-1:0] x);
    int     taps;
    int     k;
    longint acc;
    longint y;
    longint lo;
    longint hi;
    taps = int'(order_q);
    if (taps < 1) taps = 1;
    if (taps > MAX_ORDER) taps = MAX_ORDER;
    lo  = -(longint'(1) <<< (SAMPLE_BITS - 1));
    hi  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    acc = 0;
    // warm start
    if (!started[ch]) begin
      for (k = 0; k < MAX_ORDER; k++) begin
        x_hist[ch][k] = x;
        y_hist[ch][k] = x;
      end
      started[ch] = 1'b1;
    end
    for (k = MAX_ORDER - 1; k > 0; k--) x_hist[ch][k] = x_hist[ch][k-1];
    x_hist[ch][0] = x;
    for (k = 0; k < taps && k < COEF_TAPS; k++)
      acc += longint'(ff_q[k]) * longint'(x_hist[ch][k]);
    for (k = 1; k < taps && k < COEF_TAPS; k++)
      acc -= longint'(fb_q[k]) * longint'(y_hist[ch][k-1]);
    // round half up, then clamp
    y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (y < lo) y = lo;
    if (y > hi) y = hi;
    for (k = MAX_ORDER - 1; k > 0; k--) y_hist[ch][k] = y_hist[ch][k-1];
    y_hist[ch][0] = y[SAMPLE_BITS-1:0];
    return y[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) started[c] = 1'b0;
      order_q = ORDER_RESET;
      for (int t = 0; t < COEF_TAPS; t++) begin
        ff_q[t] = '0;
        fb_q[t] = '0;
      end
      ff_q[0] = FF0_RESET;
      filtered_q.delete();
      mismatch_cnt = 0;
      pending_cnt  = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        fresh.chan  = channel_i;
        fresh.value = filter_sample(int'(channel_i) % NUM_CHANNELS, sample_i);
        filtered_q.push_back(fresh);
      end
      if (out_valid_i && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction channel %0d filtered %0d",
                                    channel_out_i, filtered_i));
        end else begin
          oldest = filtered_q.pop_front();
          if (channel_out_i !== oldest.chan)
            report_mismatch($sformatf("channel_out %0d, predicted %0d",
                                      channel_out_i, oldest.chan));
          if (filtered_i !== oldest.value)
            report_mismatch($sformatf("filtered %0d on channel %0d, predicted %0d",
                                      filtered_i, oldest.chan, oldest.value));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_ORDER) begin
          order_q = cfg_data_i[ORDER_BITS-1:0];
        end else if (cfg_index_i <= REG_FF3) begin
          ff_q[cfg_index_i - REG_FF0] = cfg_data_i;
        end else if (cfg_index_i <= REG_FB3) begin
          fb_q[cfg_index_i - REG_FB1 + 1] = cfg_data_i;
        end
      end
      pending_cnt = filtered_q.size();
    end
  end

endmodule

>>> tb/multichannel_iir_filter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel iir filter core test
// drives directed and random samples and coefficient sets through the core
// under changing source and sink idling; the checker predicts each result
// ----------------------------------------------------------------------------

module multichannel_iir_filter_core_test;

  import mif_pkg::*;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [CHAN_BITS-1:0]      channel_i   = '0;
  logic signed [15:0]        sample_i    = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [CHAN_BITS-1:0]      channel_out_o;
  logic signed [15:0]        filtered_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i  = '0;

  int mismatches;
  int pending;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  multichannel_iir_filter_core #(
    .NUM_CHANNELS(8),
    .MAX_ORDER   (4),
    .SAMPLE_BITS (16)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .channel_i    (channel_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .channel_out_o(channel_out_o),
    .filtered_o   (filtered_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  multichannel_iir_filter_core_checker #(
    .NUM_CHANNELS(8),
    .MAX_ORDER   (4),
    .SAMPLE_BITS (16)
  ) filter_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .channel_i    (channel_i),
    .sample_i     (sample_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .channel_out_i(channel_out_o),
    .filtered_i   (filtered_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < sink_idle_pct);
  end

  initial begin
    #4_000_000;
    $display("multichannel_iir_filter_core_test NOT OK");
    $finish;
  end

  task automatic push_sample(input int ch, input int x);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch[CHAN_BITS-1:0];
    sample_i   <= x[15:0];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // hold off the source until every result transaction is back
  task automatic settle(input int src_pct, input int sink_pct);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[CFG_DATA_BITS-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_filter(input int order, input int ff0, input int ff1, input int ff2,
                            input int ff3, input int fb1, input int fb2, input int fb3);
    settle(src_idle_pct, sink_idle_pct);
    write_reg(REG_ORDER, order);
    write_reg(REG_FF0, ff0);
    write_reg(REG_FF0 + 3'd1, ff1);
    write_reg(REG_FF0 + 3'd2, ff2);
    write_reg(REG_FF3, ff3);
    write_reg(REG_FB1, fb1);
    write_reg(REG_FB1 + 3'd1, fb2);
    write_reg(REG_FB3, fb3);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_coef(input bit feedback);
    case ($urandom_range(5))
      0: return int'($urandom_range(262143)) - 131072;
      1: return $urandom_range(1) ? 131071 : -131072;
      default: return feedback ? int'($urandom_range(32768)) - 16384
                               : int'($urandom_range(65536)) - 32768;
    endcase
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(9))
      0: return -32768;
      1: return 32767;
      2, 3, 4, 5: return int'($urandom_range(65535)) - 32768;
      default: return int'($urandom_range(2047)) - 1024;
    endcase
  endfunction

  initial begin
    int phase;
    int epoch;
    int n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients, warm start on two channels
    push_sample(0, 32767);
    push_sample(0, -32768);
    push_sample(0, 0);
    push_sample(7, -32768);
    push_sample(7, -1);

    // largest gain, most negative feedback
    set_filter(4, 131071, 131071, 131071, 131071, -131072, -131072, -131072);
    push_sample(0, 32767);
    push_sample(7, -32768);
    push_sample(1, 32767);
    push_sample(1, -32768);

    // order zero acts as one
    set_filter(0, -131072, 131071, 131071, 131071, 131071, 131071, 131071);
    push_sample(0, 32767);
    push_sample(2, -32768);
    push_sample(2, 1);

    // order above the tap count acts as four
    set_filter(7, 32768, 16384, 16384, 16384, 131071, 131071, 131071);
    push_sample(3, 12345);
    push_sample(3, -32768);
    push_sample(3, 32767);

    // order raised mid-stream uses the older history
    set_filter(1, 65536, 16384, 16384, 16384, 8192, 8192, 8192);
    push_sample(4, 1000);
    push_sample(4, 2000);
    push_sample(4, -3000);
    set_filter(4, 65536, 16384, 16384, 16384, 8192, 8192, 8192);
    push_sample(4, 500);
    push_sample(4, 0);

    // rounding of half values
    set_filter(1, 32768, 0, 0, 0, 0, 0, 0);
    push_sample(5, 1);
    push_sample(5, -1);
    push_sample(6, -32767);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: settle(22, 64);
        1: settle(64, 22);
        default: settle(0, 0);
      endcase
      for (epoch = 0; epoch < 4; epoch++) begin
        set_filter($urandom_range(7), pick_coef(1'b0), pick_coef(1'b0), pick_coef(1'b0),
                   pick_coef(1'b0), pick_coef(1'b1), pick_coef(1'b1), pick_coef(1'b1));
        for (n = 0; n < 96; n++) push_sample($urandom_range(7), pick_sample());
      end
    end

    settle(0, 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("multichannel_iir_filter_core_test OK");
    end else begin
      $display("multichannel_iir_filter_core_test NOT OK");
    end
    $finish;
  end

endmodule
